[design/iqpao_pkg.sv]
// Package for the quadrature NCO: register codes, reset values and queue types.
// No dependencies; used by the queue, the back end and the top level.
package iqpao_pkg;

  // Configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 32;
  localparam int unsigned StepBits    = 32;
  localparam int unsigned AmpBits     = 16;
  localparam int unsigned OutBits     = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgPhaseStep = 2'd0,
    CfgAmplitude = 2'd1
  } cfg_idx_e;

  localparam logic [StepBits-1:0] StepReset = '0;
  localparam logic [AmpBits-1:0]  AmpReset  = 16'h8000;

  // Output saturation bounds
  localparam logic [OutBits-1:0] PosMax = 16'h7FFF;
  localparam logic [OutBits-1:0] NegMax = 16'h8000;

  // Queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrBits   = 2;
  localparam int unsigned QCntBits   = 3;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[design/iqpao_front.sv]
// Front end of the quadrature NCO: phase accumulator with restart.
// Emits quadrant and table index per accepted tick.
module iqpao_front #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         restart_i,
  input  logic [PHASE_BITS-1:0]        step_i,
  output logic [TABLE_ADDR_BITS+1:0]   entry_o
);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] phase_cur;

  assign phase_cur = restart_i ? '0 : phase_q;
  assign phase_d   = phase_cur + step_i;

  // quadrant on top, then table index
  assign entry_o = phase_cur[PHASE_BITS-1 -: TABLE_ADDR_BITS + 2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
    end
  end

`ifndef SYNTHESIS
  a_restart_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && restart_i |=> phase_q == $past(step_i))
    else $error("phase after restart is not one step");
`endif

endmodule

[design/iqpao_queue.sv]
// Short FIFO between front and back of the quadrature NCO.
// Depth and status type come from iqpao_pkg.
module iqpao_queue #(
  parameter int unsigned DATA_W = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [DATA_W-1:0]     data_i,
  input  logic                  pop_i,
  output logic [DATA_W-1:0]     data_o,
  output iqpao_pkg::qstat_t     stat_o
);

  logic [DATA_W-1:0] mem_q [iqpao_pkg::QueueDepth];
  logic [iqpao_pkg::QPtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [iqpao_pkg::QCntBits-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == iqpao_pkg::QCntBits'(iqpao_pkg::QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= iqpao_pkg::QCntBits'(iqpao_pkg::QueueDepth))
    else $error("queue count above depth");
  a_ptr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_ptr_q == rd_ptr_q)
    else $error("pointers differ on empty queue");
`endif

endmodule

[design/iqpao_back.sv]
// Back end of the quadrature NCO: quarter-wave ROM read, gain and saturation.
// Two-stage pipeline with output register. Uses iqpao_pkg.
module iqpao_back #(
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  iqpao_pkg::qstat_t                   qstat_i,
  input  logic [TABLE_ADDR_BITS+1:0]          entry_i,
  output logic                                pop_o,
  input  logic [iqpao_pkg::AmpBits-1:0]       amp_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [iqpao_pkg::OutBits-1:0] in_phase_o,
  output logic signed [iqpao_pkg::OutBits-1:0] quadrature_o
);

  localparam int unsigned A     = TABLE_ADDR_BITS;
  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned TblFull = 1 << A;
  localparam int unsigned ProdW = iqpao_pkg::AmpBits + S;
  localparam logic [A:0]  FullAddr = (A+1)'(TblFull);

  typedef logic [S-1:0] rom_t [0:TblFull];

  // sin(pi/2 * k / 2^A) in Q(S-1), Taylor series in Q30
  function automatic logic [S-1:0] tab_entry(int unsigned k);
    longint unsigned x, x2, term, p, r;
    longint          sum;
    int unsigned     sh;
    logic            done;
    sh   = 31 - S;
    x    = (64'(k) * 64'd1686629713) >> A;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    done = 1'b0;
    for (int unsigned n = 1; n <= 16; n++) begin
      if (!done) begin
        p = (term * x2) >> 30;
        case (n)
          1:       term = p / 6;
          2:       term = p / 20;
          3:       term = p / 42;
          4:       term = p / 72;
          5:       term = p / 110;
          6:       term = p / 156;
          7:       term = p / 210;
          8:       term = p / 272;
          9:       term = p / 342;
          10:      term = p / 420;
          11:      term = p / 506;
          12:      term = p / 600;
          13:      term = p / 702;
          14:      term = p / 812;
          15:      term = p / 930;
          default: term = p / 1056;
        endcase
        if (term == 0) begin
          done = 1'b1;
        end else if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + (64'd1 << (sh - 1))) >> sh;
    if (r > (64'd1 << (S - 1))) begin
      r = 64'd1 << (S - 1);
    end
    return r[S-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k <= TblFull; k++) begin
      t[k] = tab_entry(k);
    end
    return t;
  endfunction

  localparam rom_t RomInit = build_rom();

  function automatic logic [iqpao_pkg::OutBits-1:0] scale(
    logic [iqpao_pkg::AmpBits-1:0] amp,
    logic [S-1:0]                  mag,
    logic                          neg
  );
    logic [ProdW-1:0] prod;
    logic [16:0]      m;
    logic [15:0]      mm;
    prod = ProdW'(amp) * ProdW'(mag) + (ProdW'(1) << (S - 2));
    m    = prod[ProdW-1 -: 17];
    if (neg) begin
      mm = (m > 17'(iqpao_pkg::NegMax)) ? iqpao_pkg::NegMax : m[15:0];
      return -mm;
    end
    return (m > 17'(iqpao_pkg::PosMax)) ? iqpao_pkg::PosMax : m[15:0];
  endfunction

  logic [1:0]   quad;
  logic [A-1:0] idx;
  logic [A:0]   sin_addr, cos_addr;
  logic         advance;

  logic         s1_vld_q;
  logic [S-1:0] sin_mag_q, cos_mag_q;
  logic         sin_neg_q, cos_neg_q;

  logic         out_vld_q;
  logic [iqpao_pkg::OutBits-1:0] i_q, q_q;

  assign quad     = entry_i[A+1:A];
  assign idx      = entry_i[A-1:0];
  assign sin_addr = quad[0] ? (FullAddr - {1'b0, idx}) : {1'b0, idx};
  assign cos_addr = quad[0] ? {1'b0, idx} : (FullAddr - {1'b0, idx});

  assign advance = !out_vld_q || !out_stall_i;
  assign pop_o   = advance && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s1_vld_q  <= !qstat_i.empty;
      out_vld_q <= s1_vld_q;
    end
  end

  // ROM read, registered
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sin_mag_q <= RomInit[sin_addr];
      cos_mag_q <= RomInit[cos_addr];
      sin_neg_q <= quad[1];
      cos_neg_q <= quad[1] ^ quad[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_vld_q) begin
      i_q <= scale(amp_i, cos_mag_q, cos_neg_q);
      q_q <= scale(amp_i, sin_mag_q, sin_neg_q);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign in_phase_o   = i_q;
  assign quadrature_o = q_q;

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !advance |=> s1_vld_q)
    else $error("ROM stage dropped while stalled");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && advance |=> out_vld_q)
    else $error("ROM stage result lost");
`endif

endmodule

[design/iq_phase_accumulator_oscillator_unit.sv]
// Top level of the quadrature NCO: configuration registers, front, queue, back.
// Depends on iqpao_pkg, iqpao_front, iqpao_queue and iqpao_back.
//
//  channel | dir | handshake                    | payload
//  in      | in  | in_valid_i / in_stall_o      | restart_i
//  out     | out | out_valid_o / out_stall_i    | in_phase_o, quadrature_o
//  cfg     | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One tick accepted per cycle unless the queue is full.
// Rate is set by the phase add in the front; ROM read and gain multiply are
// each one registered stage in the back.
// Reset: phase 0, step 0, amplitude unity (32768); no clearing pass.
// in_stall_o rises only when the 4-entry queue is full (output held off).
module iq_phase_accumulator_oscillator_unit #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS     = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   restart_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [iqpao_pkg::OutBits-1:0]   in_phase_o,
  output logic signed [iqpao_pkg::OutBits-1:0]   quadrature_o,
  input  logic                                   cfg_we_i,
  input  logic [iqpao_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [iqpao_pkg::CfgDataBits-1:0]      cfg_data_i
);

  localparam int unsigned EntryW = TABLE_ADDR_BITS + 2;

  logic [iqpao_pkg::StepBits-1:0] step_q;
  logic [iqpao_pkg::AmpBits-1:0]  amp_q;

  logic              accept;
  logic              pop;
  logic [EntryW-1:0] entry_in, entry_out;
  iqpao_pkg::qstat_t qstat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= iqpao_pkg::StepReset;
      amp_q  <= iqpao_pkg::AmpReset;
    end else if (cfg_we_i) begin
      unique case (iqpao_pkg::cfg_idx_e'(cfg_idx_i))
        iqpao_pkg::CfgPhaseStep: step_q <= cfg_data_i[iqpao_pkg::StepBits-1:0];
        iqpao_pkg::CfgAmplitude: amp_q  <= cfg_data_i[iqpao_pkg::AmpBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = qstat.full;
  assign accept     = in_valid_i && !qstat.full;

  iqpao_front #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .restart_i (restart_i),
    .step_i    (PHASE_BITS'(step_q)),
    .entry_o   (entry_in)
  );

  iqpao_queue #(
    .DATA_W (EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (entry_in),
    .pop_i  (pop),
    .data_o (entry_out),
    .stat_o (qstat)
  );

  iqpao_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .entry_i      (entry_out),
    .pop_o        (pop),
    .amp_i        (amp_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .in_phase_o   (in_phase_o),
    .quadrature_o (quadrature_o)
  );

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the quadrature NCO top level.
// Depends on iqpao_pkg and iq_phase_accumulator_oscillator_unit; holds its own
// quarter-wave sine table, phase accumulator and gain model to predict I/Q.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned PhaseBits     = 32;
  localparam int unsigned TableAddrBits = 10;
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned TableSize     = 1 << TableAddrBits;
  localparam int unsigned RomShift      = 31 - SampleBits;
  localparam logic [63:0] RomFull       = 64'd1 << (SampleBits - 1);
  localparam logic [63:0] HalfPiQ30     = 64'd1686629713;
  localparam int          ResultLatency = 3;
  localparam int          MaxReports    = 10;
  localparam int          CycleLimit    = 200000;

  // Indexes past the last register; writes there must be dropped.
  localparam logic [iqpao_pkg::CfgIdxBits-1:0] CfgSpareLow  = 2'd2;
  localparam logic [iqpao_pkg::CfgIdxBits-1:0] CfgSpareHigh = 2'd3;

  typedef enum int {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  typedef struct packed {
    logic signed [iqpao_pkg::OutBits-1:0] i_val;
    logic signed [iqpao_pkg::OutBits-1:0] q_val;
  } iq_pair_t;

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_stall_o;
  logic                                   restart_i;
  logic                                   out_valid_o;
  logic                                   out_stall_i;
  logic signed [iqpao_pkg::OutBits-1:0]   in_phase_o;
  logic signed [iqpao_pkg::OutBits-1:0]   quadrature_o;
  logic                                   cfg_we_i;
  logic [iqpao_pkg::CfgIdxBits-1:0]       cfg_idx_i;
  logic [iqpao_pkg::CfgDataBits-1:0]      cfg_data_i;

  iq_phase_accumulator_oscillator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .in_phase_o  (in_phase_o),
    .quadrature_o(quadrature_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Oscillator model state
  logic [16:0]                    sine_rom [0:TableSize];
  logic [PhaseBits-1:0]           osc_phase;
  logic [iqpao_pkg::StepBits-1:0] osc_step;
  logic [iqpao_pkg::AmpBits-1:0]  osc_gain;

  iq_pair_t    expected_iq [$];
  int          error_count;
  int          cycle_count;
  stall_mode_e stall_mode;
  int          stall_left;
  int          stall_tick;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Quarter-wave entry k: Taylor series in Q30, rounded to Q15, clamped to 1.0
  function automatic logic [16:0] sine_q15_entry(input int unsigned k);
    logic [63:0] x, x2, term, r;
    longint      sum;
    bit          done;
    x    = (64'(k) * HalfPiQ30) >> TableAddrBits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    done = 1'b0;
    for (int n = 1; n <= 16; n++) begin
      if (!done) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (term == 0) done = 1'b1;
        else if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    r = (64'(sum) + (64'd1 << (RomShift - 1))) >> RomShift;
    if (r > RomFull) r = RomFull;
    return r[16:0];
  endfunction

  // Odd quadrants read the table mirrored
  function automatic logic [16:0] quarter_lookup(input logic [1:0] quad,
                                                 input logic [TableAddrBits-1:0] idx);
    return quad[0] ? sine_rom[TableSize - int'(idx)] : sine_rom[idx];
  endfunction

  // Round the gain product, then apply sign and saturate
  function automatic logic signed [iqpao_pkg::OutBits-1:0] apply_gain(
    input logic [16:0] mag,
    input logic        neg
  );
    logic [63:0] m;
    m = (64'(osc_gain) * 64'(mag) + (64'd1 << (SampleBits - 2))) >> (SampleBits - 1);
    if (neg) return (m >= 64'd32768) ? iqpao_pkg::NegMax : 16'(-m);
    return (m > 64'd32767) ? iqpao_pkg::PosMax : m[15:0];
  endfunction

  task automatic send_tick(input logic clear_phase);
    logic [1:0]               quad;
    logic [TableAddrBits-1:0] idx;
    iq_pair_t                 res;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    restart_i  <= clear_phase;
    do @(posedge clk_i); while (in_stall_o);
    if (clear_phase) osc_phase = '0;
    quad      = osc_phase[PhaseBits-1 -: 2];
    idx       = osc_phase[PhaseBits-3 -: TableAddrBits];
    res.q_val = apply_gain(quarter_lookup(quad, idx), quad[1]);
    quad      = quad + 2'd1;
    res.i_val = apply_gain(quarter_lookup(quad, idx), quad[1]);
    expected_iq.push_back(res);
    osc_phase = osc_phase + osc_step;
  endtask

  task automatic idle_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_iq.size() != 0) @(negedge clk_i);
    repeat (ResultLatency + 1) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [iqpao_pkg::CfgIdxBits-1:0] idx,
                           input logic [iqpao_pkg::CfgDataBits-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == iqpao_pkg::CfgPhaseStep) osc_step = data[iqpao_pkg::StepBits-1:0];
    else if (idx == iqpao_pkg::CfgAmplitude) osc_gain = data[iqpao_pkg::AmpBits-1:0];
  endtask

  task automatic send_stream(input int count, input int restart_pct, input bit gaps);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_tick($urandom_range(1, 100) <= restart_pct);
      left -= burst;
      if (gaps && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
    end
  endtask

  // Reset values: zero step holds phase zero, with and without restart
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // Quarter-turn step lands on every table peak and zero crossing
  task automatic test_quarter_turns();
    wait_for_results();
    write_reg(iqpao_pkg::CfgPhaseStep, 32'h4000_0000);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
  endtask

  task automatic test_gain_and_step_extremes();
    wait_for_results();
    write_reg(iqpao_pkg::CfgAmplitude, '0);
    send_tick(1'b0);
    send_tick(1'b0);
    // gain above unity; upper data bits must be dropped
    wait_for_results();
    write_reg(iqpao_pkg::CfgAmplitude, 32'hABCD_FFFF);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    // writes past the register file leave step and gain alone
    wait_for_results();
    write_reg(CfgSpareLow, 32'h1234_5678);
    write_reg(CfgSpareHigh, '1);
    send_tick(1'b0);
    send_tick(1'b0);
    // largest step walks backward by one LSB
    wait_for_results();
    write_reg(iqpao_pkg::CfgAmplitude, 32'h0000_8000);
    write_reg(iqpao_pkg::CfgPhaseStep, '1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    // one table entry per tick, then a step just past a quarter turn
    wait_for_results();
    write_reg(iqpao_pkg::CfgPhaseStep, 32'h0010_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    wait_for_results();
    write_reg(iqpao_pkg::CfgPhaseStep, 32'h4010_0000);
    send_tick(1'b0);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    logic [iqpao_pkg::StepBits-1:0] step;
    logic [iqpao_pkg::AmpBits-1:0]  gain;
    for (int p = 0; p < phases; p++) begin
      wait_for_results();
      case ($urandom_range(0, 5))
        0: step = $urandom_range(0, 32'h003F_FFFF);
        1: step = {2'($urandom_range(0, 3)), 30'd0} + $urandom_range(0, 32'h000F_FFFF)
                  - 32'h0008_0000;
        2: step = '0;
        3: step = '1;
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0: gain = '0;
        1: gain = iqpao_pkg::AmpReset;
        2: gain = 16'($urandom_range(32769, 65535));
        3: gain = '1;
        default: gain = 16'($urandom_range(0, 32768));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CfgSpareLow : CfgSpareHigh, $urandom());
      write_reg(iqpao_pkg::CfgPhaseStep, step);
      write_reg(iqpao_pkg::CfgAmplitude, {16'($urandom()), gain});
      send_stream(per_phase, $urandom_range(0, 1) ? 3 : 15, $urandom_range(0, 3) != 0);
    end
  endtask

  // Sender holds off mid-stream until the output side has fully drained
  task automatic test_pause_until_drained();
    wait_for_results();
    write_reg(iqpao_pkg::CfgPhaseStep, $urandom());
    write_reg(iqpao_pkg::CfgAmplitude, 32'($urandom_range(0, 32768)));
    send_stream(45, 5, 1'b1);
    wait_for_results();
    send_stream(45, 5, 1'b0);
  endtask

  // Receiver stall pattern, independent of the sender
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      StallNone:     out_stall_i <= 1'b0;
      StallLight:    out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy:    out_stall_i <= ($urandom_range(0, 3) != 0);
      StallPeriodic: out_stall_i <= (stall_tick % 8 < 3);
      default:       out_stall_i <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin : check_results
    iq_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_iq.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected transfer at cycle %0d: I=%0d Q=%0d",
                   cycle_count, in_phase_o, quadrature_o);
      end else begin
        want = expected_iq.pop_front();
        if (in_phase_o !== want.i_val || quadrature_o !== want.q_val) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("mismatch at cycle %0d: I exp %0d got %0d, Q exp %0d got %0d",
                     cycle_count, want.i_val, in_phase_o, want.q_val, quadrature_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("iq_phase_accumulator_oscillator_unit test failed");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    restart_i   = 1'b0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = iqpao_pkg::CfgPhaseStep;
    cfg_data_i  = '0;
    error_count = 0;
    cycle_count = 0;
    stall_mode  = StallNone;
    stall_left  = 0;
    stall_tick  = 0;
    osc_phase   = '0;
    osc_step    = iqpao_pkg::StepReset;
    osc_gain    = iqpao_pkg::AmpReset;
    for (int k = 0; k <= TableSize; k++) sine_rom[k] = sine_q15_entry(k);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_quarter_turns();
    test_gain_and_step_extremes();
    test_random_settings(9, 40);
    test_pause_until_drained();

    wait_for_results();
    repeat (2 * ResultLatency) @(posedge clk_i);
    if (error_count == 0 && expected_iq.size() == 0) begin
      $display("iq_phase_accumulator_oscillator_unit test passed");
    end else begin
      $display("iq_phase_accumulator_oscillator_unit test failed");
    end
    $finish;
  end

endmodule
